/* rtl/i2cbm_pkg.sv */
// Package for the I2C bit-level master sequencer.
// Holds the command codes and the transaction payload structs.
// No dependencies.
`default_nettype none

package i2cbm_pkg;

  typedef enum logic [2:0] {
    OP_START     = 3'd0,
    OP_STOP      = 3'd1,
    OP_WRITE     = 3'd2,
    OP_READ      = 3'd3,
    OP_SEND_ACK  = 3'd4,
    OP_RECV_ACK  = 3'd5
  } op_t;

  // Number of level phases in each command.
  localparam logic [4:0] PHASES_START_STOP = 5'd2;
  localparam logic [4:0] PHASES_BYTE       = 5'd24;
  localparam logic [4:0] PHASES_SEND_ACK   = 5'd4;
  localparam logic [4:0] PHASES_RECV_ACK   = 5'd3;

  localparam logic [15:0] PHASE_TICKS_RESET = 16'd5;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] func;
    logic [7:0] write_byte;
    logic       ack_to_send;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       nack_seen;
  } out_item_t;

endpackage

`default_nettype wire

/* rtl/i2c_bit_level_master.sv */
// I2C bit-level master sequencer: one input transaction is one timing tick.
// The result of a tick is registered and presented in the cycle after it is accepted.
// Throughput: one tick per cycle while results are taken; ready is low only
// while a result waits in the output register and out_ready is low.
// Reset (rst_n, synchronous, active low): idle, SCL and SDA released high,
// read byte and NACK flag zero, phase length 5 ticks.
`default_nettype none

module i2c_bit_level_master #(
  parameter int TICK_COUNTER_WIDTH = 16
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire i2cbm_pkg::in_item_t in_data,
  output logic                  out_valid,
  input  wire                   out_ready,
  output i2cbm_pkg::out_item_t  out_data,
  input  wire                   cfg_wr_en,
  input  wire [15:0]            cfg_wr_data
);
  import i2cbm_pkg::*;

  localparam int TW = TICK_COUNTER_WIDTH;
  localparam int XW = (TW > 16) ? TW : 16;
  localparam logic [TW-1:0] CNT_MAX = '1;

  logic [15:0]   phase_ticks_r;
  op_t           op_r, op_nxt;
  logic [4:0]    phase_r, phase_nxt;
  logic [1:0]    part_r, part_nxt;
  logic [2:0]    bit_r, bit_nxt;
  logic [TW-1:0] tick_r, tick_nxt;
  logic [7:0]    shift_r, shift_nxt;
  logic          scl_r, scl_nxt;
  logic          sda_r, sda_nxt;
  logic          busy_r, busy_nxt;
  logic          ack_r, ack_nxt;
  logic [7:0]    rbyte_r, rbyte_nxt;
  logic          done_nxt;
  logic          out_valid_r;
  out_item_t     out_data_r, out_data_nxt;

  logic          accept;
  logic [XW-1:0] limit_x;
  logic [TW-1:0] limit;
  logic [TW-1:0] tick_inc;
  logic [4:0]    phase_inc;
  logic [1:0]    lv;

  function automatic logic [4:0] phase_count(input op_t op);
    case (op)
      OP_START, OP_STOP: phase_count = PHASES_START_STOP;
      OP_WRITE, OP_READ: phase_count = PHASES_BYTE;
      OP_SEND_ACK:       phase_count = PHASES_SEND_ACK;
      default:           phase_count = PHASES_RECV_ACK;
    endcase
  endfunction

  // Levels applied at the start of a phase, returned as {scl, sda}.
  function automatic logic [1:0] apply_levels(
    input op_t        op,
    input logic [4:0] ph,
    input logic [1:0] part,
    input logic [2:0] bt,
    input logic [7:0] sh,
    input logic       scl,
    input logic       sda
  );
    logic s_c;
    logic s_d;
    s_c = scl;
    s_d = sda;
    case (op)
      OP_START: begin
        if (ph == 5'd0) begin
          s_d = 1'b1;
          s_c = 1'b1;
        end else begin
          s_d = 1'b0;
        end
      end
      OP_STOP: begin
        if (ph == 5'd0) begin
          s_d = 1'b0;
          s_c = 1'b1;
        end else begin
          s_d = 1'b1;
        end
      end
      OP_WRITE: begin
        if (part == 2'd0) s_c = 1'b0;
        else if (part == 2'd1) s_d = sh[3'd7 - bt];
        else s_c = 1'b1;
      end
      OP_READ: begin
        if (ph == 5'd0) s_d = 1'b1;
        if (part == 2'd0) s_c = 1'b0;
        else if (part == 2'd1) s_c = 1'b1;
      end
      OP_SEND_ACK: begin
        if (ph == 5'd0 || ph == 5'd3) s_c = 1'b0;
        else if (ph == 5'd1) s_d = sh[0];
        else s_c = 1'b1;
      end
      default: begin
        if (ph == 5'd0) begin
          s_d = 1'b1;
          s_c = 1'b0;
        end else if (ph == 5'd1) begin
          s_c = 1'b1;
        end else begin
          s_c = 1'b0;
        end
      end
    endcase
    apply_levels = {s_c, s_d};
  endfunction

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Effective phase length: zero counts as one, saturated at the counter maximum.
  always_comb begin
    if (phase_ticks_r == 16'd0) begin
      limit_x = XW'(1);
    end else if (XW'(phase_ticks_r) > XW'(CNT_MAX)) begin
      limit_x = XW'(CNT_MAX);
    end else begin
      limit_x = XW'(phase_ticks_r);
    end
    limit = limit_x[TW-1:0];
  end

  assign tick_inc  = (tick_r != CNT_MAX) ? tick_r + 1'b1 : tick_r;
  assign phase_inc = phase_r + 5'd1;

  always_comb begin
    op_nxt    = op_r;
    phase_nxt = phase_r;
    part_nxt  = part_r;
    bit_nxt   = bit_r;
    tick_nxt  = tick_r;
    shift_nxt = shift_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    busy_nxt  = busy_r;
    ack_nxt   = ack_r;
    rbyte_nxt = rbyte_r;
    done_nxt  = 1'b0;
    lv        = {scl_r, sda_r};

    if (busy_r) begin
      tick_nxt = tick_inc;
      if (tick_inc >= limit) begin
        // Read data and the slave's ACK are taken at the end of an SCL-high phase.
        if (op_r == OP_READ && part_r == 2'd1) shift_nxt = {shift_r[6:0], in_data.sda_in};
        if (op_r == OP_RECV_ACK && phase_r == 5'd1) ack_nxt = in_data.sda_in;
        tick_nxt = '0;
        if (phase_inc >= phase_count(op_r)) begin
          if (op_r == OP_READ) rbyte_nxt = shift_nxt;
          busy_nxt  = 1'b0;
          phase_nxt = 5'd0;
          part_nxt  = 2'd0;
          bit_nxt   = 3'd0;
          done_nxt  = 1'b1;
        end else begin
          phase_nxt = phase_inc;
          if (part_r == 2'd2) begin
            part_nxt = 2'd0;
            bit_nxt  = bit_r + 3'd1;
          end else begin
            part_nxt = part_r + 2'd1;
          end
          lv = apply_levels(op_r, phase_nxt, part_nxt, bit_nxt, shift_nxt, scl_r, sda_r);
          scl_nxt = lv[1];
          sda_nxt = lv[0];
        end
      end
    end else if (in_data.cmd_valid && in_data.func <= OP_RECV_ACK) begin
      op_nxt    = op_t'(in_data.func);
      phase_nxt = 5'd0;
      part_nxt  = 2'd0;
      bit_nxt   = 3'd0;
      tick_nxt  = '0;
      busy_nxt  = 1'b1;
      if (op_nxt == OP_WRITE) shift_nxt = in_data.write_byte;
      else if (op_nxt == OP_SEND_ACK) shift_nxt = {7'd0, in_data.ack_to_send};
      else if (op_nxt == OP_READ) shift_nxt = 8'd0;
      lv = apply_levels(op_nxt, 5'd0, 2'd0, 3'd0, shift_nxt, scl_r, sda_r);
      scl_nxt = lv[1];
      sda_nxt = lv[0];
    end

    out_data_nxt.scl_out   = scl_nxt;
    out_data_nxt.sda_out   = sda_nxt;
    out_data_nxt.busy_res  = busy_nxt;
    out_data_nxt.done_res  = done_nxt;
    out_data_nxt.read_byte = rbyte_nxt;
    out_data_nxt.nack_seen = ack_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= PHASE_TICKS_RESET;
    end else if (cfg_wr_en) begin
      phase_ticks_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r        <= OP_START;
      phase_r     <= 5'd0;
      part_r      <= 2'd0;
      bit_r       <= 3'd0;
      tick_r      <= '0;
      shift_r     <= 8'd0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      busy_r      <= 1'b0;
      ack_r       <= 1'b0;
      rbyte_r     <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        op_r        <= op_nxt;
        phase_r     <= phase_nxt;
        part_r      <= part_nxt;
        bit_r       <= bit_nxt;
        tick_r      <= tick_nxt;
        shift_r     <= shift_nxt;
        scl_r       <= scl_nxt;
        sda_r       <= sda_nxt;
        busy_r      <= busy_nxt;
        ack_r       <= ack_nxt;
        rbyte_r     <= rbyte_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload needs no reset; it is qualified by out_valid.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

`default_nettype wire

/* verif/tb_i2c_bit_level_master.sv */
// Self-checking testbench for the I2C bit-level master sequencer.
// It drives tick transactions and checks every result against an in-bench model of the sequencer or fixed levels.
// Depends on rtl/i2cbm_pkg.sv and rtl/i2c_bit_level_master.sv.
`timescale 1ns / 1ps

module tb_i2c_bit_level_master;
  import i2cbm_pkg::*;

  localparam int          PERIOD            = 10;
  localparam int          TCW               = 16;
  localparam int unsigned TICK_MAX          = 32'((64'd1 << TCW) - 64'd1);
  localparam int          FILL_DONE         = -1;
  localparam int          ITEMS_PER_SETTING = 170;
  localparam int          TAIL_CYCLES       = 4;
  localparam longint      RUN_LIMIT_NS      = 5_000_000;

  localparam out_item_t IDLE_OUT = '{scl_out: 1'b1, sda_out: 1'b1, busy_res: 1'b0,
                                     done_res: 1'b0, read_byte: 8'h00, nack_seen: 1'b0};
  localparam out_item_t START_OUT = '{scl_out: 1'b1, sda_out: 1'b1, busy_res: 1'b1,
                                      done_res: 1'b0, read_byte: 8'h00, nack_seen: 1'b0};

  typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    in_item_t    item;
    int          fill;
    bit          noisy;
    bit          typed;
    out_item_t   levels;
    logic [15:0] cfg_val;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;

  // Model of the sequencer.
  logic [15:0] phase_len;
  op_t         seq_op;
  logic [4:0]  seq_phase;
  int unsigned seq_ticks;
  logic [7:0]  seq_shift;
  logic        seq_scl;
  logic        seq_sda;
  logic        seq_busy;
  logic        seq_nack;
  logic [7:0]  seq_rbyte;

  out_item_t   levels_due[$];
  dir_row_t    plan[$];
  bit          row_typed;
  out_item_t   row_levels;
  bit          steady;
  int          accepted_cnt;
  int          errors;
  int          settings_cnt;
  int          launches[6];

  i2c_bit_level_master #(
    .TICK_COUNTER_WIDTH(TCW)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #(PERIOD / 2) clk = ~clk;

  function automatic logic [4:0] phase_total(op_t op);
    case (op)
      OP_START, OP_STOP: return PHASES_START_STOP;
      OP_WRITE, OP_READ: return PHASES_BYTE;
      OP_SEND_ACK:       return PHASES_SEND_ACK;
      default:           return PHASES_RECV_ACK;
    endcase
  endfunction

  // Levels that take effect at the start of the current phase.
  task automatic apply_levels();
    int part;
    int bitn;
    part = seq_phase % 3;
    bitn = (seq_phase / 3) % 8;
    case (seq_op)
      OP_START: begin
        if (seq_phase == 0) begin
          seq_sda = 1'b1;
          seq_scl = 1'b1;
        end else begin
          seq_sda = 1'b0;
        end
      end
      OP_STOP: begin
        if (seq_phase == 0) begin
          seq_sda = 1'b0;
          seq_scl = 1'b1;
        end else begin
          seq_sda = 1'b1;
        end
      end
      OP_WRITE: begin
        if (part == 0) seq_scl = 1'b0;
        else if (part == 1) seq_sda = seq_shift[7 - bitn];
        else seq_scl = 1'b1;
      end
      OP_READ: begin
        if (seq_phase == 0) seq_sda = 1'b1;
        if (part == 0) seq_scl = 1'b0;
        else if (part == 1) seq_scl = 1'b1;
      end
      OP_SEND_ACK: begin
        if (seq_phase == 0 || seq_phase == 3) seq_scl = 1'b0;
        else if (seq_phase == 1) seq_sda = seq_shift[0];
        else seq_scl = 1'b1;
      end
      default: begin
        if (seq_phase == 0) begin
          seq_sda = 1'b1;
          seq_scl = 1'b0;
        end else if (seq_phase == 1) begin
          seq_scl = 1'b1;
        end else begin
          seq_scl = 1'b0;
        end
      end
    endcase
  endtask

  task automatic advance_sequencer(input in_item_t it, output out_item_t res);
    int unsigned lim;
    logic        done;
    done = 1'b0;
    if (seq_busy) begin
      lim = (phase_len == 16'd0) ? 1 : phase_len;
      if (lim > TICK_MAX) lim = TICK_MAX;
      if (seq_ticks < TICK_MAX) seq_ticks++;
      if (seq_ticks >= lim) begin
        // Samples are taken on the tick that closes an SCL-high phase.
        if (seq_op == OP_READ && seq_phase % 3 == 1) seq_shift = {seq_shift[6:0], it.sda_in};
        if (seq_op == OP_RECV_ACK && seq_phase == 5'd1) seq_nack = it.sda_in;
        seq_phase++;
        seq_ticks = 0;
        if (seq_phase >= phase_total(seq_op)) begin
          if (seq_op == OP_READ) seq_rbyte = seq_shift;
          seq_busy  = 1'b0;
          seq_phase = 5'd0;
          done      = 1'b1;
        end else begin
          apply_levels();
        end
      end
    end else if (it.cmd_valid && it.func <= OP_RECV_ACK) begin
      seq_op    = op_t'(it.func);
      seq_phase = 5'd0;
      seq_ticks = 0;
      seq_busy  = 1'b1;
      case (seq_op)
        OP_WRITE:    seq_shift = it.write_byte;
        OP_SEND_ACK: seq_shift = {7'd0, it.ack_to_send};
        OP_READ:     seq_shift = 8'h00;
        default:     ;
      endcase
      launches[it.func]++;
      apply_levels();
    end
    res.scl_out   = seq_scl;
    res.sda_out   = seq_sda;
    res.busy_res  = seq_busy;
    res.done_res  = done;
    res.read_byte = seq_rbyte;
    res.nack_seen = seq_nack;
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  // Acceptance and result checking, sampled at the rising edge.
  always @(posedge clk) begin
    out_item_t pred;
    out_item_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        advance_sequencer(in_data, pred);
        levels_due.push_back(row_typed ? row_levels : pred);
        accepted_cnt++;
      end
      if (out_valid && out_ready) begin
        if (levels_due.size() == 0) begin
          $error("result transaction with no tick outstanding: %h", out_data);
          errors++;
        end else begin
          want = levels_due.pop_front();
          check_field("scl_out", want.scl_out, out_data.scl_out);
          check_field("sda_out", want.sda_out, out_data.sda_out);
          check_field("busy_res", want.busy_res, out_data.busy_res);
          check_field("done_res", want.done_res, out_data.done_res);
          check_field("read_byte", want.read_byte, out_data.read_byte);
          check_field("nack_seen", want.nack_seen, out_data.nack_seen);
        end
      end
    end
  end

  always @(negedge clk) out_ready <= steady || ($urandom_range(99) >= 11);

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_tick(input in_item_t it, input bit typed, input out_item_t lv);
    int mark;
    while (!steady && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    row_typed  = typed;
    row_levels = lv;
    in_data   <= it;
    in_valid  <= 1'b1;
    mark = accepted_cnt;
    do @(negedge clk); while (accepted_cnt == mark);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (levels_due.size() != 0) @(negedge clk);
  endtask

  task automatic write_phase_ticks(input logic [15:0] val);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    phase_len = val;
    settings_cnt++;
  endtask

  function automatic in_item_t random_tick();
    in_item_t it;
    int       r;
    it.write_byte  = 8'($urandom);
    it.ack_to_send = 1'($urandom);
    it.sda_in      = 1'($urandom);
    if (seq_busy) begin
      // Commands offered mid-sequence must be dropped.
      it.cmd_valid = ($urandom_range(99) < 30);
      it.func      = 3'($urandom);
    end else begin
      r = $urandom_range(99);
      it.cmd_valid = (r >= 6);
      it.func      = (r < 12) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
    end
    return it;
  endfunction

  function automatic dir_row_t tick_row(logic v, logic [2:0] f, logic [7:0] wb, logic ack,
                                        logic sda, int fill, bit noisy);
    dir_row_t r;
    r.kind    = ROW_TICK;
    r.item    = '{cmd_valid: v, func: f, write_byte: wb, ack_to_send: ack, sda_in: sda};
    r.fill    = fill;
    r.noisy   = noisy;
    r.typed   = 1'b0;
    r.levels  = '0;
    r.cfg_val = '0;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(logic [15:0] val);
    dir_row_t r;
    r = tick_row(1'b0, 3'd0, 8'h00, 1'b0, 1'b0, 0, 1'b0);
    r.kind    = ROW_CFG;
    r.cfg_val = val;
    return r;
  endfunction

  function automatic dir_row_t known(dir_row_t r, out_item_t lv);
    r.typed  = 1'b1;
    r.levels = lv;
    return r;
  endfunction

  initial begin
    #(RUN_LIMIT_NS);
    $display("i2c_bit_level_master: mismatch");
    $finish;
  end

  initial begin
    logic [15:0] len_plan[10];
    in_item_t    ft;
    int          n;
    len_plan = '{16'd1, 16'd2, 16'd0, 16'd4, 16'd1, 16'd3, 16'd5, 16'd1, 16'd2, 16'd7};

    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    steady      = 1'b0;
    row_typed   = 1'b0;
    row_levels  = '0;
    phase_len   = PHASE_TICKS_RESET;
    seq_op      = OP_START;
    seq_phase   = '0;
    seq_ticks   = 0;
    seq_shift   = '0;
    seq_scl     = 1'b1;
    seq_sda     = 1'b1;
    seq_busy    = 1'b0;
    seq_nack    = 1'b0;
    seq_rbyte   = '0;

    // Directed plan: reset values, dropped codes, every command, those with data at both data extremes,
    // zero phase length, and a phase length change in the middle of a write.
    plan.push_back(known(tick_row(1'b0, OP_START, 8'h00, 1'b0, 1'b0, 0, 1'b0), IDLE_OUT));
    plan.push_back(known(tick_row(1'b1, 3'd6, 8'hFF, 1'b1, 1'b1, 0, 1'b0), IDLE_OUT));
    plan.push_back(known(tick_row(1'b1, 3'd7, 8'h00, 1'b0, 1'b0, 0, 1'b0), IDLE_OUT));
    plan.push_back(known(tick_row(1'b1, OP_START, 8'h00, 1'b0, 1'b1, FILL_DONE, 1'b1),
                         START_OUT));
    plan.push_back(tick_row(1'b1, OP_STOP, 8'h00, 1'b0, 1'b0, FILL_DONE, 1'b0));
    plan.push_back(cfg_row(16'd0));
    plan.push_back(tick_row(1'b1, OP_WRITE, 8'hFF, 1'b0, 1'b0, FILL_DONE, 1'b0));
    plan.push_back(tick_row(1'b1, OP_WRITE, 8'h00, 1'b1, 1'b1, FILL_DONE, 1'b0));
    plan.push_back(tick_row(1'b1, OP_READ, 8'h00, 1'b0, 1'b1, FILL_DONE, 1'b0));
    plan.push_back(tick_row(1'b1, OP_READ, 8'hFF, 1'b1, 1'b0, FILL_DONE, 1'b0));
    plan.push_back(tick_row(1'b1, OP_SEND_ACK, 8'h00, 1'b0, 1'b0, FILL_DONE, 1'b0));
    plan.push_back(tick_row(1'b1, OP_SEND_ACK, 8'hFF, 1'b1, 1'b1, FILL_DONE, 1'b0));
    plan.push_back(tick_row(1'b1, OP_RECV_ACK, 8'h00, 1'b0, 1'b1, FILL_DONE, 1'b0));
    plan.push_back(tick_row(1'b1, OP_RECV_ACK, 8'h00, 1'b0, 1'b0, FILL_DONE, 1'b0));
    plan.push_back(cfg_row(16'd1));
    plan.push_back(tick_row(1'b1, OP_WRITE, 8'hA5, 1'b0, 1'b0, 5, 1'b0));
    plan.push_back(cfg_row(16'hFFFF));
    plan.push_back(tick_row(1'b0, OP_START, 8'h00, 1'b0, 1'b0, 20, 1'b1));
    plan.push_back(cfg_row(16'd1));
    plan.push_back(tick_row(1'b0, OP_START, 8'h00, 1'b0, 1'b0, FILL_DONE, 1'b0));
    plan.push_back(cfg_row(16'd3));
    plan.push_back(tick_row(1'b1, OP_READ, 8'h00, 1'b0, 1'b1, FILL_DONE, 1'b1));
    plan.push_back(tick_row(1'b1, OP_RECV_ACK, 8'h00, 1'b0, 1'b1, FILL_DONE, 1'b1));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        write_phase_ticks(plan[i].cfg_val);
      end else begin
        send_tick(plan[i].item, plan[i].typed, plan[i].levels);
        n = 0;
        while ((plan[i].fill < 0) ? seq_busy : (n < plan[i].fill)) begin
          ft = plan[i].item;
          ft.cmd_valid = plan[i].noisy;
          ft.func      = 3'($urandom);
          send_tick(ft, 1'b0, '0);
          n++;
        end
      end
    end

    foreach (len_plan[k]) begin
      write_phase_ticks(len_plan[k]);
      steady = (k == 3);
      repeat (ITEMS_PER_SETTING) send_tick(random_tick(), 1'b0, '0);
    end
    steady = 1'b0;

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Covered %0d ticks: %0d start, %0d stop, %0d write, %0d read, %0d ack-out, %0d ack-in",
             accepted_cnt, launches[OP_START], launches[OP_STOP], launches[OP_WRITE],
             launches[OP_READ], launches[OP_SEND_ACK], launches[OP_RECV_ACK]);
    $display("across %0d phase length settings, with idle, ignored and mid-command ticks.",
             settings_cnt);
    if (errors == 0) begin
      $display("i2c_bit_level_master: match");
    end else begin
      $display("i2c_bit_level_master: mismatch");
    end
    $finish;
  end

endmodule
